/* rtl/clt_pkg.sv */
package clt_pkg;

    localparam int SLOT_COUNT = 8;
    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    localparam logic [14:0] MAX_DELAY = 15'd30000;
    localparam logic [14:0] OVERDUE_DELAY = 15'd1000;
    localparam logic [31:0] PROBE_RESET = 32'd5000;
    localparam logic [31:0] DEAD_RESET = 32'd10000;

    localparam logic [0:0] REG_PROBE = 1'b0;
    localparam logic [0:0] REG_DEAD = 1'b1;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_SEEN   = 2'd2,
        CMD_TICK   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        EV_DONE   = 3'd0,
        EV_FAILED = 3'd1,
        EV_PROBE  = 3'd2,
        EV_DROP   = 3'd3,
        EV_TICK   = 3'd4
    } event_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINAL
    } state_t;

    // token that walks down the row of cells, one cell per cycle unless a probe or drop is held off
    typedef struct packed {
        logic        valid;
        logic [1:0]  command;
        logic [15:0] client_id;
        logic [47:0] now_ms;
        logic        found;    // a slot was already claimed by this item
        logic [14:0] delay;
    } token_t;

    // report of one cell to the controller while the token is inside it
    typedef struct packed {
        logic        fire;     // probe or drop to emit
        logic        drop;
        logic [15:0] client;
    } cell_rpt_t;

endpackage

/* rtl/client_liveness_table.sv */
// Keep-alive table of clt_pkg::SLOT_COUNT client slots built as a row of cells.
// Each item travels down the row one cell per cycle unless a probe or drop waits
// on the result side; the cell adds, removes or restamps its slot, flags
// probe/drop on a tick and folds its deadline into the next-delay estimate.
// Probe and drop items are sent while the scan goes on, so they hold the scan
// only while the result side holds off. One item is in the row at a time.
// Config writes belong in the gaps when no item is in flight.
module client_liveness_table (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [15:0] s_client_id,
    input  logic [47:0] s_now_ms,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_event_kind,
    output logic [15:0] m_event_client,
    output logic [14:0] m_next_delay_ms,
    output logic        m_last_result
);

    localparam int N = clt_pkg::SLOT_COUNT;

    clt_pkg::state_t state_reg, state_next;
    logic [clt_pkg::SLOT_W-1:0] pos_reg, pos_next;
    clt_pkg::token_t tok_reg, tok_next;
    logic [31:0] probe_reg, dead_reg;

    clt_pkg::token_t    chain [N+1];
    clt_pkg::token_t    tok_at [N];
    clt_pkg::cell_rpt_t rpt [N];
    logic [N-1:0] step_v;

    logic        out_valid_reg;
    logic [2:0]  kind_reg;
    logic [15:0] client_reg;
    logic [14:0] delay_reg;
    logic        last_reg;
    logic        out_free;
    clt_pkg::cell_rpt_t cur;

    assign out_free = !out_valid_reg || m_ready;

    // only the cell that holds the token sees it
    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            assign tok_at[g] = (state_reg == clt_pkg::ST_SCAN && pos_reg == clt_pkg::SLOT_W'(g))
                               ? tok_reg : '0;
            clt_cell u_cell (
                .aclk(aclk), .aresetn(aresetn), .step(step_v[g]),
                .probe_period_ms(probe_reg), .dead_after_ms(dead_reg),
                .tok_in(tok_at[g]), .tok_out(chain[g+1]), .rpt(rpt[g])
            );
        end
    endgenerate
    assign chain[0] = '0;

    always_comb begin
        cur = '0;
        for (int i = 0; i < N; i++)
            if (pos_reg == i[clt_pkg::SLOT_W-1:0]) cur = rpt[i];
    end

    logic scan_go;
    assign scan_go = !(cur.fire && !out_free);

    always_comb begin
        for (int i = 0; i < N; i++)
            step_v[i] = state_reg == clt_pkg::ST_SCAN && scan_go
                        && pos_reg == i[clt_pkg::SLOT_W-1:0];
    end

    always_comb begin
        state_next = state_reg;
        pos_next = pos_reg;
        tok_next = tok_reg;
        unique case (state_reg)
            clt_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = clt_pkg::ST_SCAN;
                    pos_next = '0;
                    tok_next.valid = 1'b1;
                    tok_next.command = s_command;
                    tok_next.client_id = s_client_id;
                    tok_next.now_ms = s_now_ms;
                    tok_next.found = 1'b0;
                    tok_next.delay = clt_pkg::MAX_DELAY;
                end
            end
            clt_pkg::ST_SCAN: begin
                if (scan_go) begin
                    tok_next = '0;
                    for (int i = 0; i < N; i++)
                        if (pos_reg == i[clt_pkg::SLOT_W-1:0]) tok_next = chain[i+1];
                    if (pos_reg == clt_pkg::SLOT_W'(N - 1)) state_next = clt_pkg::ST_FINAL;
                    else pos_next = pos_reg + clt_pkg::SLOT_W'(1);
                end
            end
            clt_pkg::ST_FINAL: begin
                if (out_free) state_next = clt_pkg::ST_IDLE;
            end
            default: state_next = clt_pkg::ST_IDLE;
        endcase
    end

    assign s_ready = state_reg == clt_pkg::ST_IDLE;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= clt_pkg::ST_IDLE;
            pos_reg <= '0;
            tok_reg <= '0;
            probe_reg <= clt_pkg::PROBE_RESET;
            dead_reg <= clt_pkg::DEAD_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            pos_reg <= pos_next;
            tok_reg <= tok_next;
            if (cfg_we) begin
                if (cfg_index == clt_pkg::REG_PROBE) probe_reg <= cfg_data;
                else dead_reg <= cfg_data;
            end
            if (state_reg == clt_pkg::ST_SCAN && cur.fire && out_free)
                out_valid_reg <= 1'b1;
            else if (state_reg == clt_pkg::ST_FINAL && out_free)
                out_valid_reg <= 1'b1;
            else if (m_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == clt_pkg::ST_SCAN && cur.fire && out_free) begin
            kind_reg <= cur.drop ? clt_pkg::EV_DROP : clt_pkg::EV_PROBE;
            client_reg <= cur.client;
            delay_reg <= '0;
            last_reg <= 1'b0;
        end else if (state_reg == clt_pkg::ST_FINAL && out_free) begin
            if (tok_reg.command == clt_pkg::CMD_TICK) kind_reg <= clt_pkg::EV_TICK;
            else kind_reg <= tok_reg.found ? clt_pkg::EV_DONE : clt_pkg::EV_FAILED;
            client_reg <= tok_reg.client_id;
            delay_reg <= tok_reg.delay;
            last_reg <= 1'b1;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_event_kind = kind_reg;
    assign m_event_client = client_reg;
    assign m_next_delay_ms = delay_reg;
    assign m_last_result = last_reg;

endmodule

/* rtl/clt_cell.sv */
module clt_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic [31:0]       probe_period_ms,
    input  logic [31:0]       dead_after_ms,
    input  clt_pkg::token_t   tok_in,
    output clt_pkg::token_t   tok_out,
    output clt_pkg::cell_rpt_t rpt
);

    logic        used_reg;
    logic [15:0] client_reg;
    logic [47:0] seen_reg;

    logic        match;
    logic        claim;
    logic [48:0] due;
    logic [48:0] dead;
    logic [48:0] now_w;
    logic [48:0] lim;
    logic        used_after;
    logic [47:0] seen_after;
    clt_pkg::token_t tok;

    always_comb begin
        now_w = {1'b0, tok_in.now_ms};
        match = used_reg && (client_reg == tok_in.client_id);
        claim = 1'b0;
        if (tok_in.valid && !tok_in.found) begin
            unique case (tok_in.command)
                clt_pkg::CMD_ADD:    claim = !used_reg;
                clt_pkg::CMD_REMOVE: claim = match;
                clt_pkg::CMD_SEEN:   claim = match;
                default:             claim = 1'b0;
            endcase
        end
        used_after = used_reg;
        seen_after = seen_reg;
        if (claim) begin
            unique case (tok_in.command)
                clt_pkg::CMD_ADD:    begin used_after = 1'b1; seen_after = tok_in.now_ms; end
                clt_pkg::CMD_REMOVE: used_after = 1'b0;
                default:             seen_after = tok_in.now_ms;
            endcase
        end
        due  = {1'b0, seen_after} + {17'd0, probe_period_ms};
        dead = {1'b0, seen_after} + {17'd0, dead_after_ms};
        lim  = now_w + {34'd0, tok_in.delay};
        tok = tok_in;
        tok.found = tok_in.found | claim;
        if (tok_in.valid && used_after && due < lim) begin
            if (due < now_w) tok.delay = clt_pkg::OVERDUE_DELAY;
            else             tok.delay = 15'(due - now_w);
        end
        rpt.fire   = tok_in.valid && tok_in.command == clt_pkg::CMD_TICK
                     && used_reg && due <= now_w;
        rpt.drop   = dead <= now_w;
        rpt.client = client_reg;
        tok_out    = tok;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= 1'b0;
        end else if (step && claim) begin
            used_reg <= used_after;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && claim) begin
            seen_reg <= seen_after;
            if (tok_in.command == clt_pkg::CMD_ADD) client_reg <= tok_in.client_id;
        end
    end

endmodule

/* bench/tb_client_liveness_table.sv */
`timescale 1ns / 1ps

module tb_client_liveness_table;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] client;
        logic [14:0] delay;
        logic        last;
    } event_rec_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic        cfg_index;
    logic [31:0] cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_command;
    logic [15:0] s_client_id;
    logic [47:0] s_now_ms;
    logic        m_valid;
    logic        m_ready;
    logic [2:0]  m_event_kind;
    logic [15:0] m_event_client;
    logic [14:0] m_next_delay_ms;
    logic        m_last_result;

    // predictor copy of the table
    logic [31:0] prd_period;
    logic [31:0] prd_dead;
    logic        prd_used [clt_pkg::SLOT_COUNT];
    logic [15:0] prd_client [clt_pkg::SLOT_COUNT];
    logic [47:0] prd_seen [clt_pkg::SLOT_COUNT];

    event_rec_t pending_events[$];
    int         error_count;
    int         send_idle_pct;
    int         recv_idle_pct;
    int         hold_off_cycles;
    logic [47:0] clock_ms;

    client_liveness_table i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_client_id     (s_client_id),
        .s_now_ms        (s_now_ms),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_event_kind    (m_event_kind),
        .m_event_client  (m_event_client),
        .m_next_delay_ms (m_next_delay_ms),
        .m_last_result   (m_last_result)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #200ms;
        $display("Test completed with failures");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [47:0] got,
                                   input logic [47:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic logic [14:0] calc_next_delay(input logic [47:0] now);
        logic [49:0] delay;
        logic [49:0] due;
        delay = 50'(clt_pkg::MAX_DELAY);
        for (int i = 0; i < clt_pkg::SLOT_COUNT; i++) begin
            if (prd_used[i]) begin
                due = 50'(prd_seen[i]) + 50'(prd_period);
                if (due < delay + 50'(now))
                    delay = (due < 50'(now)) ? 50'(clt_pkg::OVERDUE_DELAY) : due - 50'(now);
            end
        end
        return delay[14:0];
    endfunction

    function automatic int find_slot(input logic [15:0] id);
        for (int i = 0; i < clt_pkg::SLOT_COUNT; i++)
            if (prd_used[i] && prd_client[i] == id)
                return i;
        return -1;
    endfunction

    task automatic predict_item(input clt_pkg::cmd_t cmd, input logic [15:0] id,
                                input logic [47:0] now);
        event_rec_t ev;
        int idx;
        logic ok;
        ok = 1'b0;
        case (cmd)
            clt_pkg::CMD_ADD: begin
                for (int i = 0; i < clt_pkg::SLOT_COUNT; i++) begin
                    if (!ok && !prd_used[i]) begin
                        prd_used[i] = 1'b1;
                        prd_client[i] = id;
                        prd_seen[i] = now;
                        ok = 1'b1;
                    end
                end
            end
            clt_pkg::CMD_REMOVE: begin
                idx = find_slot(id);
                if (idx >= 0) begin
                    prd_used[idx] = 1'b0;
                    ok = 1'b1;
                end
            end
            clt_pkg::CMD_SEEN: begin
                idx = find_slot(id);
                if (idx >= 0) begin
                    prd_seen[idx] = now;
                    ok = 1'b1;
                end
            end
            default: begin
                for (int i = 0; i < clt_pkg::SLOT_COUNT; i++) begin
                    if (prd_used[i] && 49'(prd_seen[i]) + 49'(prd_period) <= 49'(now)) begin
                        ev.kind = (49'(prd_seen[i]) + 49'(prd_dead) <= 49'(now)) ?
                                  clt_pkg::EV_DROP : clt_pkg::EV_PROBE;
                        ev.client = prd_client[i];
                        ev.delay = '0;
                        ev.last = 1'b0;
                        pending_events.push_back(ev);
                    end
                end
            end
        endcase
        ev.kind = (cmd == clt_pkg::CMD_TICK) ? clt_pkg::EV_TICK :
                  (ok ? clt_pkg::EV_DONE : clt_pkg::EV_FAILED);
        ev.client = id;
        ev.delay = calc_next_delay(now);
        ev.last = 1'b1;
        pending_events.push_back(ev);
    endtask

    task automatic send_item(input clt_pkg::cmd_t cmd, input logic [15:0] id,
                             input logic [47:0] now);
        while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct)
            @(negedge aclk);
        s_valid = 1'b1;
        s_command = cmd;
        s_client_id = id;
        s_now_ms = now;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        predict_item(cmd, id, now);
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_events.size() != 0)
            @(negedge aclk);
        repeat (clt_pkg::SLOT_COUNT + 20) @(negedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] value);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (idx == clt_pkg::REG_PROBE)
            prd_period = value;
        else
            prd_dead = value;
    endtask

    // result checker
    always @(posedge aclk) begin
        event_rec_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_events.size() == 0) begin
                report_mismatch("unexpected item", 48'(m_event_kind), 48'd0);
            end else begin
                want = pending_events.pop_front();
                if (m_event_kind !== want.kind)
                    report_mismatch("event_kind", 48'(m_event_kind), 48'(want.kind));
                if (m_event_client !== want.client)
                    report_mismatch("event_client", 48'(m_event_client), 48'(want.client));
                if (m_next_delay_ms !== want.delay)
                    report_mismatch("next_delay_ms", 48'(m_next_delay_ms), 48'(want.delay));
                if (m_last_result !== want.last)
                    report_mismatch("last_result", 48'(m_last_result), 48'(want.last));
            end
        end
    end

    // receiver ready, with an optional long hold-off
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_cycles > 0) begin
                m_ready <= 1'b0;
                hold_off_cycles--;
            end else begin
                m_ready <= !(recv_idle_pct > 0 && $urandom_range(99, 0) < recv_idle_pct);
            end
        end
    end

    task automatic test_directed();
        send_item(clt_pkg::CMD_TICK, 16'hFFFF, 48'd0);
        send_item(clt_pkg::CMD_REMOVE, 16'h0000, 48'd0);
        send_item(clt_pkg::CMD_SEEN, 16'hFFFF, 48'd0);
        for (int i = 0; i < clt_pkg::SLOT_COUNT; i++)
            send_item(clt_pkg::CMD_ADD, (i == 0) ? 16'hFFFF : 16'(i * 3), 48'(i * 700));
        send_item(clt_pkg::CMD_ADD, 16'h0042, 48'd100);
        send_item(clt_pkg::CMD_ADD, 16'hFFFF, 48'd100);
        send_item(clt_pkg::CMD_SEEN, 16'h0003, 48'd9000);
        send_item(clt_pkg::CMD_TICK, 16'h1234, 48'd6000);
        send_item(clt_pkg::CMD_TICK, 16'h0000, 48'd12000);
        send_item(clt_pkg::CMD_REMOVE, 16'hFFFF, 48'd12000);
        send_item(clt_pkg::CMD_ADD, 16'hAAAA, 48'hFFFF_FFFF_FFFF);
        send_item(clt_pkg::CMD_TICK, 16'h5555, 48'hFFFF_FFFF_FFFF);
        send_item(clt_pkg::CMD_TICK, 16'h0001, 48'd30);
        for (int i = 0; i < clt_pkg::SLOT_COUNT; i++)
            send_item(clt_pkg::CMD_REMOVE, (i == 0) ? 16'hAAAA : 16'(i * 3), 48'd0);
    endtask

    task automatic test_random(input int count);
        logic [15:0] id;
        int roll;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(99, 0);
            id = ($urandom_range(3, 0) == 0) ? 16'($urandom) : 16'($urandom_range(7, 0));
            clock_ms = clock_ms + 48'($urandom_range(4000, 0));
            if (roll < 5)
                send_item(clt_pkg::cmd_t'($urandom_range(3, 0)), 16'($urandom),
                          {16'($urandom), 32'($urandom)});
            else if (roll < 30)
                send_item(clt_pkg::CMD_ADD, id, clock_ms);
            else if (roll < 45)
                send_item(clt_pkg::CMD_REMOVE, id, clock_ms);
            else if (roll < 65)
                send_item(clt_pkg::CMD_SEEN, id, clock_ms - 48'($urandom_range(3000, 0)));
            else
                send_item(clt_pkg::CMD_TICK, 16'($urandom), clock_ms);
        end
    endtask

    task automatic test_backpressure();
        wait_drained();
        hold_off_cycles = 400;
        for (int i = 0; i < 12; i++)
            send_item(i < 6 ? clt_pkg::CMD_ADD : clt_pkg::CMD_TICK, 16'(i),
                      clock_ms + 48'(i * 3000));
        wait_drained();
        clock_ms = clock_ms + 48'd40000;
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = 1'b0;
        cfg_data = '0;
        s_valid = 1'b0;
        s_command = clt_pkg::CMD_ADD;
        s_client_id = '0;
        s_now_ms = '0;
        error_count = 0;
        hold_off_cycles = 0;
        clock_ms = 48'd1000;
        send_idle_pct = 8;
        recv_idle_pct = 85;
        prd_period = clt_pkg::PROBE_RESET;
        prd_dead = clt_pkg::DEAD_RESET;
        for (int i = 0; i < clt_pkg::SLOT_COUNT; i++) begin
            prd_used[i] = 1'b0;
            prd_client[i] = '0;
            prd_seen[i] = '0;
        end
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed();
        test_random(60);
        write_reg(clt_pkg::REG_PROBE, 32'd1);
        write_reg(clt_pkg::REG_DEAD, 32'd1);
        send_idle_pct = 85;
        recv_idle_pct = 8;
        test_random(40);
        write_reg(clt_pkg::REG_PROBE, 32'hFFFF_FFFF);
        write_reg(clt_pkg::REG_DEAD, 32'hFFFF_FFFF);
        test_random(30);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(clt_pkg::REG_PROBE, 32'd2000);
        write_reg(clt_pkg::REG_DEAD, 32'd6000);
        test_backpressure();
        test_random(60);
        write_reg(clt_pkg::REG_PROBE, 32'd0);
        write_reg(clt_pkg::REG_DEAD, 32'd0);
        test_random(20);

        wait_drained();
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* filelist.f */
rtl/clt_pkg.sv
rtl/clt_cell.sv
rtl/client_liveness_table.sv
bench/tb_client_liveness_table.sv
